// ===== rtl/qse_pkg.sv =====
// Package for the quicksort engine: sizes, transaction payload types and
// value conversion helpers. No dependencies.
`default_nettype none

package qse_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int DATA_WIDTH  = 32;
  localparam int STORE_DEPTH = 64;
  localparam int IDX_W       = 6;
  localparam int CNT_W       = 7;
  localparam int FIELD_W     = 32;
  localparam int WIDE_W      = (DATA_WIDTH > FIELD_W) ? DATA_WIDTH : FIELD_W;

  typedef logic [DATA_WIDTH-1:0] data_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] item_value;
    logic                      item_last;
  } in_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] sorted_value;
    logic                      sorted_last;
    logic                      overflow;
  } out_t;

  // Keep the low DATA_WIDTH bits of an input value.
  function automatic data_t to_store(input logic [FIELD_W-1:0] v);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(v);
    return w[DATA_WIDTH-1:0];
  endfunction

  // Keep the low FIELD_W bits of a stored value, zero extended if narrower.
  function automatic logic [FIELD_W-1:0] to_field(input data_t d);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(d);
    return w[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/qse_core.sv =====
// Load buffer, range stack and partition sequencer of the quicksort engine.
// Depends on qse_pkg.
`default_nettype none

module qse_core (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qse_pkg::in_t  in_data,
  output logic               core_valid,
  input  wire logic          core_ready,
  output qse_pkg::out_t      core_data
);
  import qse_pkg::*;

  localparam logic [3:0] S_LOAD      = 4'd0;
  localparam logic [3:0] S_INIT      = 4'd1;
  localparam logic [3:0] S_POP       = 4'd2;
  localparam logic [3:0] S_POP_WAIT  = 4'd3;
  localparam logic [3:0] S_PIV_WAIT  = 4'd4;
  localparam logic [3:0] S_SCAN      = 4'd5;
  localparam logic [3:0] S_CMP       = 4'd6;
  localparam logic [3:0] S_SWAP_A    = 4'd7;
  localparam logic [3:0] S_SWAP_B    = 4'd8;
  localparam logic [3:0] S_FIN_WAIT  = 4'd9;
  localparam logic [3:0] S_FIN_B     = 4'd10;
  localparam logic [3:0] S_PUSH_L    = 4'd11;
  localparam logic [3:0] S_PUSH_R    = 4'd12;
  localparam logic [3:0] S_EMIT_RD   = 4'd13;
  localparam logic [3:0] S_EMIT_WAIT = 4'd14;

  localparam int RANGE_W = 2 * IDX_W;

  data_t              elem_mem [STORE_DEPTH];
  logic [RANGE_W-1:0] stack_mem [STORE_DEPTH];

  logic [3:0] state_r, state_nxt;
  cnt_t       count_r, count_nxt;
  logic       dropped_r, dropped_nxt;
  cnt_t       top_r, top_nxt;
  idx_t       lo_r, lo_nxt, hi_r, hi_nxt, s_r, s_nxt, j_r, j_nxt, k_r, k_nxt;
  data_t      pivot_r, pivot_nxt, vtmp_r, vtmp_nxt;
  data_t      elem_rd_r;
  logic [RANGE_W-1:0] stk_rd_r;

  logic               elem_we;
  idx_t               elem_wa, elem_ra;
  data_t              elem_wd;
  logic               stk_we;
  idx_t               stk_wa, stk_ra;
  logic [RANGE_W-1:0] stk_wd;

  idx_t  pop_lo, pop_hi;
  logic  le_pivot;
  logic  emit_last;
  cnt_t  n_minus_1;
  cnt_t  top_dec;

  assign pop_lo    = stk_rd_r[RANGE_W-1:IDX_W];
  assign pop_hi    = stk_rd_r[IDX_W-1:0];
  assign le_pivot  = signed'(elem_rd_r) <= signed'(pivot_r);
  assign emit_last = (CNT_W'(k_r) + CNT_W'(1)) == count_r;
  assign n_minus_1 = count_r - CNT_W'(1);
  assign top_dec   = top_r - CNT_W'(1);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    top_nxt     = top_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    s_nxt       = s_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    pivot_nxt   = pivot_r;
    vtmp_nxt    = vtmp_r;
    elem_we     = 1'b0;
    elem_wa     = s_r;
    elem_wd     = vtmp_r;
    elem_ra     = j_r;
    stk_we      = 1'b0;
    stk_wa      = top_r[IDX_W-1:0];
    stk_wd      = {lo_r, hi_r};
    stk_ra      = top_dec[IDX_W-1:0];
    in_ready    = 1'b0;
    core_valid  = 1'b0;
    core_data.sorted_value = to_field(elem_rd_r);
    core_data.sorted_last  = emit_last;
    core_data.overflow     = dropped_r;

    case (state_r)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count_r < CNT_W'(MAX_ITEMS)) begin
            elem_we   = 1'b1;
            elem_wa   = count_r[IDX_W-1:0];
            elem_wd   = to_store(in_data.item_value);
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_data.item_last) begin
            state_nxt = S_INIT;
          end
        end
      end
      S_INIT: begin
        if (count_r < CNT_W'(2)) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          stk_we    = 1'b1;
          stk_wa    = '0;
          stk_wd    = {IDX_W'(0), n_minus_1[IDX_W-1:0]};
          top_nxt   = CNT_W'(1);
          state_nxt = S_POP;
        end
      end
      S_POP: begin
        if (top_r == '0) begin
          k_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end else begin
          top_nxt   = top_dec;
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        if (pop_lo >= pop_hi) begin
          state_nxt = S_POP;
        end else begin
          elem_ra   = pop_hi;
          lo_nxt    = pop_lo;
          hi_nxt    = pop_hi;
          s_nxt     = pop_lo;
          j_nxt     = pop_lo;
          state_nxt = S_PIV_WAIT;
        end
      end
      S_PIV_WAIT: begin
        pivot_nxt = elem_rd_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (j_r == hi_r) begin
          elem_ra   = s_r;
          state_nxt = S_FIN_WAIT;
        end else begin
          elem_ra   = j_r;
          state_nxt = S_CMP;
        end
      end
      S_CMP: begin
        if (le_pivot) begin
          if (s_r == j_r) begin
            s_nxt     = s_r + IDX_W'(1);
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = S_SCAN;
          end else begin
            vtmp_nxt  = elem_rd_r;
            elem_ra   = s_r;
            state_nxt = S_SWAP_A;
          end
        end else begin
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = S_SCAN;
        end
      end
      S_SWAP_A: begin
        // The scanned element goes to the left slot; the old left value is kept.
        elem_we   = 1'b1;
        elem_wa   = s_r;
        elem_wd   = vtmp_r;
        vtmp_nxt  = elem_rd_r;
        state_nxt = S_SWAP_B;
      end
      S_SWAP_B: begin
        elem_we   = 1'b1;
        elem_wa   = j_r;
        elem_wd   = vtmp_r;
        s_nxt     = s_r + IDX_W'(1);
        j_nxt     = j_r + IDX_W'(1);
        state_nxt = S_SCAN;
      end
      S_FIN_WAIT: begin
        elem_we   = 1'b1;
        elem_wa   = hi_r;
        elem_wd   = elem_rd_r;
        state_nxt = S_FIN_B;
      end
      S_FIN_B: begin
        elem_we   = 1'b1;
        elem_wa   = s_r;
        elem_wd   = pivot_r;
        state_nxt = S_PUSH_L;
      end
      S_PUSH_L: begin
        if ((CNT_W'(s_r) > CNT_W'(lo_r) + CNT_W'(1)) &&
            (top_r < CNT_W'(STORE_DEPTH))) begin
          stk_we  = 1'b1;
          stk_wd  = {lo_r, s_r - IDX_W'(1)};
          top_nxt = top_r + CNT_W'(1);
        end
        state_nxt = S_PUSH_R;
      end
      S_PUSH_R: begin
        if ((CNT_W'(s_r) + CNT_W'(1) < CNT_W'(hi_r)) &&
            (top_r < CNT_W'(STORE_DEPTH))) begin
          stk_we  = 1'b1;
          stk_wd  = {s_r + IDX_W'(1), hi_r};
          top_nxt = top_r + CNT_W'(1);
        end
        state_nxt = S_POP;
      end
      S_EMIT_RD: begin
        elem_ra   = k_r;
        state_nxt = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        elem_ra    = k_r;
        core_valid = 1'b1;
        if (core_ready) begin
          if (emit_last) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            state_nxt   = S_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      top_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      top_r     <= top_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    s_r     <= s_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    pivot_r <= pivot_nxt;
    vtmp_r  <= vtmp_nxt;
  end

  always_ff @(posedge clk) begin
    if (elem_we) begin
      elem_mem[elem_wa] <= elem_wd;
    end
    elem_rd_r <= elem_mem[elem_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    stk_rd_r <= stack_mem[stk_ra];
  end

endmodule

`default_nettype wire

// ===== rtl/qse_out_stage.sv =====
// Output register of the quicksort engine: holds one result transaction so
// the sequencer can move on while the consumer stalls. Depends on qse_pkg.
`default_nettype none

module qse_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          core_valid,
  output logic               core_ready,
  input  wire qse_pkg::out_t core_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qse_pkg::out_t      out_data
);
  import qse_pkg::*;

  logic valid_r;
  out_t data_r;

  assign core_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (core_ready) begin
      valid_r <= core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      data_r <= core_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/quicksort_engine_top.sv =====
// Quicksort engine, top level. Loading accepts one item per cycle. After the
// closing item, setup pushes the full range; each partition pass then pops a
// range, reads its pivot, scans and exchanges elements and places the pivot,
// all on one element memory with one read and one write port. Input is not
// ready from the closing item until the final result is handed to the output
// register. Results leave one at a time through a one-entry output register.
// Reset (synchronous, rst_n low) empties the list and clears the overflow
// flag; the element and range memories are not cleared.
`default_nettype none

module quicksort_engine_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire qse_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output qse_pkg::out_t      out_data
);
  import qse_pkg::*;

  logic core_valid;
  logic core_ready;
  out_t core_data;

  qse_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .core_valid (core_valid),
    .core_ready (core_ready),
    .core_data  (core_data)
  );

  qse_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .core_valid (core_valid),
    .core_ready (core_ready),
    .core_data  (core_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  // The sequencer never loads and emits at the same time.
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(core_valid && in_ready))
    else $error("input accepted while a result is being emitted");

  // Handing over the final result of a run returns the block to loading.
  a_last_reopens_load: assert property (@(posedge clk) disable iff (!rst_n)
    (core_valid && core_ready && core_data.sorted_last) |=> in_ready)
    else $error("block did not return to loading after the final result");

  // A result handed to the output register is visible on the next cycle.
  a_result_reaches_port: assert property (@(posedge clk) disable iff (!rst_n)
    (core_valid && core_ready) |=> out_valid)
    else $error("result handed over but not presented");

endmodule

`default_nettype wire
